// ----- design/indexed_doubly_linked_list_unit_macros.svh -----
// Assertion macros for the indexed doubly linked list unit.
`ifndef INDEXED_DOUBLY_LINKED_LIST_UNIT_MACROS_SVH
`define INDEXED_DOUBLY_LINKED_LIST_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge, paused while reset is low.
`define IDLL_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("idll assertion failed");
// Checked on every rising clock edge, reset included.
`define IDLL_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("idll assertion failed");
`else
`define IDLL_ASSERT_RST(label, clk, rst_n, prop)
`define IDLL_ASSERT(label, clk, prop)
`endif

`endif

// ----- design/idll_pkg.sv -----
`timescale 1ns / 1ps

package idll_pkg;

  localparam int OP_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_START   = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_SWAP    = 3'd3,
    OP_REVERSE = 3'd4,
    OP_QUERY   = 3'd5
  } op_e;

endpackage

// ----- design/idll_in_if.sv -----
`timescale 1ns / 1ps

interface idll_in_if #(
  parameter int NODE_W = 11
) ();
  logic                      valid;
  logic                      ready;
  logic [idll_pkg::OP_W-1:0] op;
  logic [NODE_W-1:0]         node_a;
  logic [NODE_W-1:0]         node_b;
  logic                      side;

  modport source (output valid, output op, output node_a, output node_b, output side,
                  input ready);
  modport sink   (input valid, input op, input node_a, input node_b, input side,
                  output ready);
endinterface

// ----- design/idll_out_if.sv -----
`timescale 1ns / 1ps

interface idll_out_if #(
  parameter int NODE_W = 11
) ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] next_node;
  logic              end_of_list;

  modport source (output valid, output next_node, output end_of_list, input ready);
  modport sink   (input valid, input next_node, input end_of_list, output ready);
endinterface

// ----- design/idll_link_ram.sv -----
`timescale 1ns / 1ps

module idll_link_ram #(
  parameter int DEPTH = 1026,
  parameter int WIDTH = 11,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i && ({1'b0, waddr_i} < DEPTH_V)) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- design/idll_ctrl.sv -----
`timescale 1ns / 1ps
`include "indexed_doubly_linked_list_unit_macros.svh"

module idll_ctrl #(
  parameter int MAX_NODES = 1024,
  localparam int NODE_W = $clog2(MAX_NODES + 2)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [idll_pkg::OP_W-1:0] op_i,
  input  logic [NODE_W-1:0]         node_a_i,
  input  logic [NODE_W-1:0]         node_b_i,
  input  logic                      side_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic [NODE_W-1:0]         next_node_o,
  output logic                      end_of_list_o
);

  localparam int DEPTH = MAX_NODES + 2;
  localparam logic [NODE_W-1:0] HEAD_ID = '0;
  localparam logic [NODE_W-1:0] MAX_ID  = NODE_W'(MAX_NODES);
  localparam logic [NODE_W-1:0] TAIL_ID = NODE_W'(MAX_NODES + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD1  = 6'b000010,
    S_RD2  = 6'b000100,
    S_PLAN = 6'b001000,
    S_WR   = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [NODE_W-1:0] data;
  } link_wr_t;

  function automatic link_wr_t wr_op(input logic [NODE_W-1:0] addr,
                                     input logic [NODE_W-1:0] data);
    return '{en: 1'b1, addr: addr, data: data};
  endfunction

  state_e                    state_q, state_d;
  logic [idll_pkg::OP_W-1:0] op_q;
  logic [NODE_W-1:0]         a_q, b_q;
  logic                      side_q;
  logic                      rev_q;
  logic [NODE_W-1:0]         lj_q, rj_q;
  link_wr_t                  lw_q [4];
  link_wr_t                  lw_d [4];
  link_wr_t                  rw_q [4];
  link_wr_t                  rw_d [4];
  logic [1:0]                last_q, last_d;
  logic [1:0]                step_q;
  logic                      has_wr_d;
  logic [NODE_W-1:0]         next_q, next_d;
  logic                      end_q, end_d;

  logic                      valid_a, valid_b;
  logic                      rd_en;
  logic [NODE_W-1:0]         raddr;
  logic [NODE_W-1:0]         l_rdata, r_rdata;
  logic                      l_we, r_we;
  logic [NODE_W-1:0]         q_val, q_stop;

  assign valid_a = (a_q != HEAD_ID) && (a_q <= MAX_ID);
  assign valid_b = (b_q != HEAD_ID) && (b_q <= MAX_ID);

  // first read: reference node (j for swap), second read: node a for swap
  always_comb begin
    rd_en = 1'b0;
    raddr = HEAD_ID;
    if (state_q == S_RD1) begin
      rd_en = 1'b1;
      unique case (op_q)
        idll_pkg::OP_INSERT: raddr = valid_b ? b_q : HEAD_ID;
        idll_pkg::OP_SWAP:   raddr = valid_b ? b_q : HEAD_ID;
        idll_pkg::OP_REMOVE: raddr = valid_a ? a_q : HEAD_ID;
        idll_pkg::OP_QUERY: begin
          if (a_q > MAX_ID) begin
            raddr = HEAD_ID;
          end else if (rev_q && (a_q == HEAD_ID)) begin
            raddr = TAIL_ID;
          end else begin
            raddr = a_q;
          end
        end
        default: rd_en = 1'b0;
      endcase
    end else if (state_q == S_RD2) begin
      rd_en = (op_q == idll_pkg::OP_SWAP) && valid_a;
      raddr = a_q;
    end
  end

  assign l_we = (state_q == S_WR) && lw_q[step_q].en;
  assign r_we = (state_q == S_WR) && rw_q[step_q].en;

  idll_link_ram #(
    .DEPTH (DEPTH),
    .WIDTH (NODE_W)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (lw_q[step_q].addr),
    .wdata_i (lw_q[step_q].data),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (l_rdata)
  );

  idll_link_ram #(
    .DEPTH (DEPTH),
    .WIDTH (NODE_W)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (rw_q[step_q].addr),
    .wdata_i (rw_q[step_q].data),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (r_rdata)
  );

  assign q_val  = rev_q ? lj_q : rj_q;
  assign q_stop = rev_q ? HEAD_ID : TAIL_ID;

  // write plan, in the order each link store must see its writes
  // lj/rj: links of b (or of a for remove and query), l_rdata/r_rdata: links of a
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lw_d[k] = '0;
      rw_d[k] = '0;
    end
    last_d   = 2'd0;
    has_wr_d = 1'b0;
    next_d   = HEAD_ID;
    end_d    = 1'b0;
    unique case (op_q)
      idll_pkg::OP_START: begin
        if (valid_a) begin
          lw_d[0]  = wr_op(a_q, HEAD_ID);
          lw_d[1]  = wr_op(TAIL_ID, a_q);
          rw_d[0]  = wr_op(HEAD_ID, a_q);
          rw_d[1]  = wr_op(a_q, TAIL_ID);
          last_d   = 2'd1;
          has_wr_d = 1'b1;
        end
      end
      idll_pkg::OP_INSERT: begin
        if (valid_a && valid_b) begin
          if (side_q == rev_q) begin
            rw_d[0] = wr_op(lj_q, a_q);
            rw_d[1] = wr_op(a_q, b_q);
            lw_d[0] = wr_op(a_q, lj_q);
            lw_d[1] = wr_op(b_q, a_q);
          end else begin
            lw_d[0] = wr_op(rj_q, a_q);
            lw_d[1] = wr_op(a_q, b_q);
            rw_d[0] = wr_op(a_q, rj_q);
            rw_d[1] = wr_op(b_q, a_q);
          end
          last_d   = 2'd1;
          has_wr_d = 1'b1;
        end
      end
      idll_pkg::OP_REMOVE: begin
        if (valid_a) begin
          rw_d[0]  = wr_op(lj_q, rj_q);
          lw_d[0]  = wr_op(rj_q, lj_q);
          has_wr_d = 1'b1;
        end
      end
      idll_pkg::OP_SWAP: begin
        if (valid_a && valid_b) begin
          has_wr_d = 1'b1;
          if (a_q == lj_q) begin
            rw_d[0] = wr_op(l_rdata, b_q);
            rw_d[1] = wr_op(a_q, rj_q);
            rw_d[2] = wr_op(b_q, a_q);
            lw_d[0] = wr_op(b_q, l_rdata);
            lw_d[1] = wr_op(rj_q, a_q);
            lw_d[2] = wr_op(a_q, b_q);
            last_d  = 2'd2;
          end else if (a_q == rj_q) begin
            rw_d[0] = wr_op(lj_q, a_q);
            rw_d[1] = wr_op(b_q, r_rdata);
            rw_d[2] = wr_op(a_q, b_q);
            lw_d[0] = wr_op(a_q, lj_q);
            lw_d[1] = wr_op(r_rdata, b_q);
            lw_d[2] = wr_op(b_q, a_q);
            last_d  = 2'd2;
          end else begin
            lw_d[0] = wr_op(rj_q, a_q);
            lw_d[1] = wr_op(r_rdata, b_q);
            lw_d[2] = wr_op(a_q, lj_q);
            lw_d[3] = wr_op(b_q, l_rdata);
            rw_d[0] = wr_op(lj_q, a_q);
            rw_d[1] = wr_op(l_rdata, b_q);
            rw_d[2] = wr_op(a_q, rj_q);
            rw_d[3] = wr_op(b_q, r_rdata);
            last_d  = 2'd3;
          end
        end
      end
      idll_pkg::OP_QUERY: begin
        if (a_q > MAX_ID) begin
          end_d = 1'b1;
        end else if (q_val == q_stop) begin
          end_d = 1'b1;
        end else begin
          next_d = q_val;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_PLAN;
      S_PLAN: state_d = has_wr_d ? S_WR : S_DONE;
      S_WR:   if (step_q == last_q) state_d = S_DONE;
      S_DONE: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rev_q   <= 1'b0;
      step_q  <= 2'd0;
      last_q  <= 2'd0;
      for (int k = 0; k < 4; k++) begin
        lw_q[k] <= '0;
        rw_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_PLAN) begin
        if (op_q == idll_pkg::OP_REVERSE) begin
          rev_q <= ~rev_q;
        end
        step_q <= 2'd0;
        last_q <= last_d;
        for (int k = 0; k < 4; k++) begin
          lw_q[k] <= lw_d[k];
          rw_q[k] <= rw_d[k];
        end
      end else if (state_q == S_WR) begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      op_q   <= op_i;
      a_q    <= node_a_i;
      b_q    <= node_b_i;
      side_q <= side_i;
    end
    if (state_q == S_RD2) begin
      lj_q <= l_rdata;
      rj_q <= r_rdata;
    end
    if (state_q == S_PLAN) begin
      next_q <= next_d;
      end_q  <= end_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign res_valid_o   = (state_q == S_DONE);
  assign next_node_o   = next_q;
  assign end_of_list_o = end_q;

  `IDLL_ASSERT(a_write_only_in_wr, clk_i, (l_we || r_we) |-> (state_q == S_WR))
  `IDLL_ASSERT_RST(a_accept_starts_read, clk_i, rst_ni,
                   (in_valid_i && in_ready_o) |=> (state_q == S_RD1))
  `IDLL_ASSERT_RST(a_step_in_plan, clk_i, rst_ni, (state_q == S_WR) |-> (step_q <= last_q))
  `IDLL_ASSERT_RST(a_rev_on_reverse_only, clk_i, rst_ni,
                   (rev_q != $past(rev_q)) |->
                   (($past(state_q) == S_PLAN) && ($past(op_q) == idll_pkg::OP_REVERSE)))
  `IDLL_ASSERT_RST(a_no_write_for_query, clk_i, rst_ni,
                   (state_q == S_WR) |->
                   ((op_q != idll_pkg::OP_QUERY) && (op_q != idll_pkg::OP_REVERSE)))

endmodule

// ----- design/indexed_doubly_linked_list_unit.sv -----
`timescale 1ns / 1ps
// Indexed doubly linked list unit.
// in_i (sink) takes one item per operation: op, node_a, node_b, side.
// out_o (source) returns exactly one item per input item, in order:
// next_node and end_of_list for a query, zeros for every other op.
// Both channels move an item on a clock edge with valid and ready high.
// The host issues a start op before any op that reads links.
// Items are worked one at a time: each passes the states read one, read
// two and plan, then W write steps, then a done state that holds the
// result until the output register takes it. W is 0 for query, reverse and
// ops with invalid nodes, 1 for remove, 2 for start and insert, 3 for a swap of adjacent nodes, 4 for other swaps.
// W is set by the single write port of each of the two link memories.
// An output register parts the sides: the next item is taken while a
// result waits; a stalled receiver holds the unit once a second result
// is ready. Reset clears the reversed flag and all handshake state;
// link memories are not cleared.
module indexed_doubly_linked_list_unit #(
  parameter int MAX_NODES = 1024
) (
  input logic        clk_i,
  input logic        rst_ni,
  idll_in_if.sink    in_i,
  idll_out_if.source out_o
);

  localparam int NODE_W = $clog2(MAX_NODES + 2);

  logic              res_valid;
  logic              res_ready;
  logic [NODE_W-1:0] res_next;
  logic              res_end;

  logic              out_valid_q;
  logic [NODE_W-1:0] out_next_q;
  logic              out_end_q;

  idll_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .op_i          (in_i.op),
    .node_a_i      (in_i.node_a),
    .node_b_i      (in_i.node_b),
    .side_i        (in_i.side),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .next_node_o   (res_next),
    .end_of_list_o (res_end)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_next_q <= res_next;
      out_end_q  <= res_end;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.next_node   = out_next_q;
  assign out_o.end_of_list = out_end_q;

endmodule

// ----- tb/sv/tb_indexed_doubly_linked_list_unit.sv -----
`timescale 1ns / 1ps

module link_store_model #(
  parameter int MAX = 1024
) ();

  localparam int NW = 11;
  localparam logic [NW-1:0] TAIL = NW'(MAX + 1);

  logic [NW-1:0] lft [0:MAX+1];
  logic [NW-1:0] rgt [0:MAX+1];
  bit            lft_ok [0:MAX+1];
  bit            rgt_ok [0:MAX+1];
  bit            rev;

  // nodes reachable from the head, in physical order
  logic [NW-1:0] chain [$];
  bit            listed [0:MAX+1];

  function automatic bit is_node(logic [NW-1:0] x);
    return x >= 1 && x <= MAX;
  endfunction

  function automatic logic [NW-1:0] get_l(logic [NW-1:0] x);
    return (x <= TAIL) ? lft[x] : '0;
  endfunction

  function automatic logic [NW-1:0] get_r(logic [NW-1:0] x);
    return (x <= TAIL) ? rgt[x] : '0;
  endfunction

  function automatic void put_l(logic [NW-1:0] x, logic [NW-1:0] v);
    if (x <= TAIL) begin
      lft[x] = v;
      lft_ok[x] = 1'b1;
    end
  endfunction

  function automatic void put_r(logic [NW-1:0] x, logic [NW-1:0] v);
    if (x <= TAIL) begin
      rgt[x] = v;
      rgt_ok[x] = 1'b1;
    end
  endfunction

  // true when the op touches only link entries that hold a written value
  function automatic bit reads_ok(logic [idll_pkg::OP_W-1:0] op, logic [NW-1:0] a,
                                  logic [NW-1:0] b);
    case (op)
      idll_pkg::OP_INSERT: return !(is_node(a) && is_node(b)) || (lft_ok[b] && rgt_ok[b]);
      idll_pkg::OP_REMOVE: return !is_node(a) || (lft_ok[a] && rgt_ok[a]);
      idll_pkg::OP_SWAP:   return !(is_node(a) && is_node(b)) ||
                                  (lft_ok[a] && rgt_ok[a] && lft_ok[b] && rgt_ok[b]);
      idll_pkg::OP_QUERY: begin
        if (a > MAX) return 1'b1;
        if (rev) return (a == 0) ? lft_ok[TAIL] : lft_ok[a];
        return rgt_ok[a];
      end
      default:   return 1'b1;
    endcase
  endfunction

  function automatic void step(input logic [idll_pkg::OP_W-1:0] op, input logic [NW-1:0] a,
                               input logic [NW-1:0] b, input logic side,
                               output logic [NW-1:0] nxt, output logic eol);
    logic [NW-1:0] p, q, r, s, v;
    nxt = '0;
    eol = 1'b0;
    case (op)
      idll_pkg::OP_START: if (is_node(a)) begin
        put_l(a, '0);
        put_r('0, a);
        put_r(a, TAIL);
        put_l(TAIL, a);
      end
      idll_pkg::OP_INSERT: if (is_node(a) && is_node(b)) begin
        if (side == rev) begin
          p = get_l(b);
          put_r(p, a);
          put_l(a, p);
          put_r(a, b);
          put_l(b, a);
        end else begin
          q = get_r(b);
          put_l(q, a);
          put_r(a, q);
          put_l(a, b);
          put_r(b, a);
        end
      end
      idll_pkg::OP_REMOVE: if (is_node(a)) begin
        p = get_l(a);
        q = get_r(a);
        put_r(p, q);
        put_l(q, p);
      end
      idll_pkg::OP_SWAP: if (is_node(a) && is_node(b)) begin
        if (a == get_l(b)) begin
          p = get_l(a);
          q = get_r(b);
          put_r(p, b);
          put_l(b, p);
          put_l(q, a);
          put_r(a, q);
          put_r(b, a);
          put_l(a, b);
        end else if (a == get_r(b)) begin
          p = get_l(b);
          q = get_r(a);
          put_r(p, a);
          put_l(a, p);
          put_l(q, b);
          put_r(b, q);
          put_l(b, a);
          put_r(a, b);
        end else begin
          p = get_l(a);
          q = get_r(a);
          r = get_l(b);
          s = get_r(b);
          put_l(s, a);
          put_r(r, a);
          put_l(q, b);
          put_r(p, b);
          put_l(a, r);
          put_r(a, s);
          put_l(b, p);
          put_r(b, q);
        end
      end
      idll_pkg::OP_REVERSE: rev = ~rev;
      idll_pkg::OP_QUERY: begin
        if (a > MAX) begin
          eol = 1'b1;
        end else begin
          if (rev) v = (a == 0) ? get_l(TAIL) : get_l(a);
          else v = get_r(a);
          if (v == (rev ? '0 : TAIL)) eol = 1'b1;
          else nxt = v;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void refresh();
    logic [NW-1:0] x, y;
    foreach (chain[k]) listed[chain[k]] = 1'b0;
    chain.delete();
    x = '0;
    while (rgt_ok[x]) begin
      y = rgt[x];
      if (!is_node(y) || listed[y]) break;
      listed[y] = 1'b1;
      chain.push_back(y);
      x = y;
    end
  endfunction
endmodule

module tb_indexed_doubly_linked_list_unit;

  localparam int NODE_W = 11;
  localparam int MAX_NODES = 1024;
  localparam int N_ITEMS = 1900;
  localparam int IDLE_PCT = 35;
  localparam int DRAIN_AT = 400;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [idll_pkg::OP_W-1:0] OP_UNUSED_A = 3'd6;
  localparam logic [idll_pkg::OP_W-1:0] OP_UNUSED_B = 3'd7;

  typedef struct packed {
    logic [idll_pkg::OP_W-1:0] op;
    logic [NODE_W-1:0]         node_a;
    logic [NODE_W-1:0]         node_b;
    logic                      side;
  } list_cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] next_node;
    logic              end_of_list;
  } list_rsp_t;

  logic clk_i;
  logic rst_ni;

  idll_in_if  #(.NODE_W(NODE_W)) cmd_if ();
  idll_out_if #(.NODE_W(NODE_W)) rsp_if ();

  indexed_doubly_linked_list_unit #(
    .MAX_NODES(MAX_NODES)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (rsp_if)
  );

  // plan_list steers stimulus ahead of time, live_list follows accepted items
  link_store_model #(.MAX(MAX_NODES)) plan_list ();
  link_store_model #(.MAX(MAX_NODES)) live_list ();

  list_cmd_t   cmd_q [$];
  list_rsp_t   expected_rsp_q [$];
  int unsigned taken_cnt = 0;
  int unsigned shown_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_cnt = 0;
  logic        steady;

  assign steady = (taken_cnt >= 900 && taken_cnt < 1250);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [NODE_W-1:0] pick_node();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return NODE_W'($urandom_range(1, 64));
    if (roll < 90) return NODE_W'($urandom_range(MAX_NODES - 1, MAX_NODES));
    return NODE_W'($urandom_range(1, MAX_NODES));
  endfunction

  function automatic void plan_cmd(logic [idll_pkg::OP_W-1:0] op, logic [NODE_W-1:0] a,
                                   logic [NODE_W-1:0] b, logic side);
    logic [NODE_W-1:0] nx;
    logic              eo;
    if (!plan_list.reads_ok(op, a, b)) return;
    plan_list.step(op, a, b, side, nx, eo);
    plan_list.refresh();
    cmd_q.push_back('{op: op, node_a: a, node_b: b, side: side});
  endfunction

  initial begin
    logic [NODE_W-1:0] a, b, t;
    logic              sd;
    int unsigned       roll, n, k, j;

    rst_ni        = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.op     = '0;
    cmd_if.node_a = '0;
    cmd_if.node_b = '0;
    cmd_if.side   = 1'b0;
    rsp_if.ready  = 1'b0;

    plan_cmd(idll_pkg::OP_START, 1, 0, 0);
    plan_cmd(idll_pkg::OP_QUERY, 0, 0, 0);
    plan_cmd(idll_pkg::OP_QUERY, 1, 0, 0);
    plan_cmd(idll_pkg::OP_INSERT, 1024, 1, 1);
    plan_cmd(idll_pkg::OP_INSERT, 2, 1024, 0);
    plan_cmd(idll_pkg::OP_QUERY, 1025, 2047, 1);
    plan_cmd(idll_pkg::OP_QUERY, 2047, 0, 0);
    plan_cmd(idll_pkg::OP_REVERSE, 0, 0, 0);
    plan_cmd(idll_pkg::OP_QUERY, 0, 0, 0);
    plan_cmd(idll_pkg::OP_INSERT, 3, 2, 1);
    plan_cmd(idll_pkg::OP_SWAP, 3, 2, 0);
    plan_cmd(idll_pkg::OP_SWAP, 3, 2, 1);
    plan_cmd(idll_pkg::OP_SWAP, 1, 1024, 0);
    plan_cmd(idll_pkg::OP_SWAP, 2, 2, 0);
    plan_cmd(idll_pkg::OP_QUERY, 1024, 0, 0);
    plan_cmd(idll_pkg::OP_REVERSE, 2047, 2047, 1);
    plan_cmd(idll_pkg::OP_REMOVE, 3, 0, 0);
    plan_cmd(OP_UNUSED_A, 2047, 2047, 1);
    plan_cmd(OP_UNUSED_B, 1024, 1, 0);
    plan_cmd(idll_pkg::OP_START, 0, 5, 0);
    plan_cmd(idll_pkg::OP_START, 1025, 0, 1);
    plan_cmd(idll_pkg::OP_INSERT, 5, 0, 1);
    plan_cmd(idll_pkg::OP_SWAP, 1, 2047, 0);
    plan_cmd(idll_pkg::OP_REMOVE, 1025, 0, 0);
    // restart, then work on nodes dropped from the list
    plan_cmd(idll_pkg::OP_START, 7, 0, 0);
    plan_cmd(idll_pkg::OP_INSERT, 8, 7, 0);
    plan_cmd(idll_pkg::OP_REMOVE, 1, 0, 0);
    plan_cmd(idll_pkg::OP_INSERT, 9, 2, 1);
    plan_cmd(idll_pkg::OP_QUERY, 0, 0, 0);

    while (cmd_q.size() < N_ITEMS) begin
      n = plan_list.chain.size();
      roll = $urandom_range(0, 99);
      a = pick_node();
      b = NODE_W'($urandom_range(0, 2047));
      sd = 1'($urandom_range(0, 1));
      if (n == 0 || cmd_q.size() % 300 == 0) begin
        plan_cmd(idll_pkg::OP_START, a, b, sd);
      end else if (roll < 30) begin
        for (k = 0; k < 8 && plan_list.listed[a]; k++) a = pick_node();
        plan_cmd(idll_pkg::OP_INSERT, a, plan_list.chain[$urandom_range(0, n - 1)], sd);
      end else if (roll < 42) begin
        plan_cmd(idll_pkg::OP_REMOVE, plan_list.chain[$urandom_range(0, n - 1)], b, sd);
      end else if (roll < 58) begin
        k = $urandom_range(0, n - 1);
        if ($urandom_range(0, 1)) j = (k + 1 < n) ? k + 1 : ((k > 0) ? k - 1 : k);
        else j = $urandom_range(0, n - 1);
        a = plan_list.chain[k];
        t = plan_list.chain[j];
        if (sd) plan_cmd(idll_pkg::OP_SWAP, a, t, sd);
        else plan_cmd(idll_pkg::OP_SWAP, t, a, sd);
      end else if (roll < 64) begin
        plan_cmd(idll_pkg::OP_REVERSE, a, b, sd);
      end else if (roll < 95) begin
        k = $urandom_range(0, 9);
        if (k < 2) a = '0;
        else if (k < 8) a = plan_list.chain[$urandom_range(0, n - 1)];
        else if (k < 9) a = NODE_W'($urandom_range(MAX_NODES + 1, 2047));
        plan_cmd(idll_pkg::OP_QUERY, a, b, sd);
      end else begin
        plan_cmd(idll_pkg::OP_W'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 2047)),
                 b, sd);
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_q.size() != 0 || expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_indexed_doubly_linked_list_unit: clean");
    end else begin
      $display("tb_indexed_doubly_linked_list_unit: errors");
    end
    $finish;
  end

  // driver: an item stays on the bus until taken
  always @(negedge clk_i) begin
    if (rst_ni && !(cmd_if.valid && shown_cnt != taken_cnt)) begin
      if (cmd_q.size() != 0 && !(taken_cnt == DRAIN_AT && expected_rsp_q.size() != 0) &&
          (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cmd_if.valid  <= 1'b1;
        cmd_if.op     <= cmd_q[0].op;
        cmd_if.node_a <= cmd_q[0].node_a;
        cmd_if.node_b <= cmd_q[0].node_b;
        cmd_if.side   <= cmd_q[0].side;
        shown_cnt     <= taken_cnt + 1;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      rsp_if.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // monitor: check results first, then predict from the item taken at this edge
  list_rsp_t         want;
  logic [NODE_W-1:0] pred_next;
  logic              pred_end;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (rsp_if.valid && rsp_if.ready) begin
        quiet_cycles = 0;
        if (expected_rsp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected item, expected none, actual next_node %0d end_of_list %0d",
                   $time, rsp_if.next_node, rsp_if.end_of_list);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_if.next_node !== want.next_node) begin
            err_cnt++;
            $display("%0t: next_node expected %0d actual %0d",
                     $time, want.next_node, rsp_if.next_node);
          end
          if (rsp_if.end_of_list !== want.end_of_list) begin
            err_cnt++;
            $display("%0t: end_of_list expected %0d actual %0d",
                     $time, want.end_of_list, rsp_if.end_of_list);
          end
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        quiet_cycles = 0;
        void'(cmd_q.pop_front());
        live_list.step(cmd_if.op, cmd_if.node_a, cmd_if.node_b, cmd_if.side,
                       pred_next, pred_end);
        expected_rsp_q.push_back('{next_node: pred_next, end_of_list: pred_end});
        taken_cnt++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_indexed_doubly_linked_list_unit: errors");
        $finish;
      end
    end
  end
endmodule
